/* design/slst_pkg.sv */
// Shared package for the stochastic Lorenz step core: types, register codes,
// reset values, the saturating adder and the micro-program of one integration step.
// Used by slst_alu, slst_cfg_regs and stochastic_lorenz_step_core.
`timescale 1ns / 1ps
`default_nettype none

package slst_pkg;

  // Sizes
  localparam int unsigned IndexBits   = 16;
  localparam int unsigned NumOps      = 33;
  localparam int unsigned PcBits      = 6;
  localparam int unsigned TmpAddrBits = 3;

  // Fixed-point constants
  localparam logic [31:0] QOne   = 32'h0001_0000;
  localparam logic [31:0] SatMax = 32'h7fff_ffff;
  localparam logic [31:0] SatMin = 32'h8000_0000;

  // Register reset values, unsigned Q15.16
  localparam logic [30:0] ResetCoefA  = 31'd655360;
  localparam logic [30:0] ResetCoefB  = 31'd1835008;
  localparam logic [30:0] ResetCoefC  = 31'd174763;
  localparam logic [30:0] ResetStepH  = 31'd655;
  localparam logic [30:0] ResetSqrtH  = 31'd6554;
  localparam logic [30:0] ResetSigma  = 31'd0;
  localparam logic [30:0] ResetSpread = 31'd0;

  typedef enum logic [0:0] {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    CFG_COEF_A = 3'd0,
    CFG_COEF_B = 3'd1,
    CFG_COEF_C = 3'd2,
    CFG_STEP_H = 3'd3,
    CFG_SQRT_H = 3'd4,
    CFG_SIGMA  = 3'd5,
    CFG_SPREAD = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] coef_a;
    logic [30:0] coef_b;
    logic [30:0] coef_c;
    logic [30:0] step_h;
    logic [30:0] sqrt_h;
    logic [30:0] sigma;
    logic [30:0] spread;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_MUL16 = 2'd0,
    OP_MUL12 = 2'd1,
    OP_ADD   = 2'd2,
    OP_SUB   = 2'd3
  } alu_op_e;

  // Operand sources: scratch entries first, then named values
  typedef enum logic [4:0] {
    SRC_T0  = 5'd0,
    SRC_T1  = 5'd1,
    SRC_T2  = 5'd2,
    SRC_T3  = 5'd3,
    SRC_T4  = 5'd4,
    SRC_T5  = 5'd5,
    SRC_T6  = 5'd6,
    SRC_T7  = 5'd7,
    SRC_X   = 5'd8,
    SRC_Y   = 5'd9,
    SRC_Z   = 5'd10,
    SRC_A   = 5'd11,
    SRC_B   = 5'd12,
    SRC_C   = 5'd13,
    SRC_H   = 5'd14,
    SRC_SQH = 5'd15,
    SRC_SIG = 5'd16,
    SRC_SPR = 5'd17,
    SRC_NW  = 5'd18,
    SRC_NA  = 5'd19,
    SRC_NB  = 5'd20,
    SRC_NC  = 5'd21,
    SRC_ONE = 5'd22
  } src_e;

  // Result destinations: scratch entries, then the point coordinates
  typedef enum logic [3:0] {
    DST_T0 = 4'd0,
    DST_T1 = 4'd1,
    DST_T2 = 4'd2,
    DST_T3 = 4'd3,
    DST_T4 = 4'd4,
    DST_T5 = 4'd5,
    DST_T6 = 4'd6,
    DST_T7 = 4'd7,
    DST_X  = 4'd8,
    DST_Y  = 4'd9,
    DST_Z  = 4'd10
  } dst_e;

  typedef struct packed {
    alu_op_e op;
    dst_e    dst;
    src_e    sa;
    src_e    sb;
  } instr_t;

  // Signed 32-bit add or subtract, saturated to the 32-bit range.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                          input logic sub);
    logic [32:0] s;
    s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
    if (s[32] != s[31]) begin
      sat_add = s[32] ? SatMin : SatMax;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // One Euler-Maruyama step as a sequence of operations on the shared unit.
  // T0 holds the Wiener increment; the point is written only by the last three.
  function automatic instr_t prog(input logic [PcBits-1:0] pc);
    instr_t i;
    case (pc)
      // Wiener increment and the x update
      6'd0:    i = '{OP_MUL12, DST_T0, SRC_SQH, SRC_NW};
      6'd1:    i = '{OP_MUL12, DST_T1, SRC_SPR, SRC_NA};
      6'd2:    i = '{OP_ADD,   DST_T1, SRC_ONE, SRC_T1};
      6'd3:    i = '{OP_MUL16, DST_T1, SRC_A,   SRC_T1};
      6'd4:    i = '{OP_MUL16, DST_T1, SRC_H,   SRC_T1};
      6'd5:    i = '{OP_SUB,   DST_T2, SRC_Y,   SRC_X};
      6'd6:    i = '{OP_MUL16, DST_T1, SRC_T1,  SRC_T2};
      6'd7:    i = '{OP_ADD,   DST_T1, SRC_X,   SRC_T1};
      6'd8:    i = '{OP_MUL16, DST_T2, SRC_SIG, SRC_X};
      6'd9:    i = '{OP_MUL16, DST_T2, SRC_T2,  SRC_T0};
      // y update
      6'd10:   i = '{OP_MUL12, DST_T3, SRC_SPR, SRC_NB};
      6'd11:   i = '{OP_ADD,   DST_T3, SRC_ONE, SRC_T3};
      6'd12:   i = '{OP_MUL16, DST_T3, SRC_B,   SRC_T3};
      6'd13:   i = '{OP_SUB,   DST_T3, SRC_T3,  SRC_Z};
      6'd14:   i = '{OP_MUL16, DST_T3, SRC_X,   SRC_T3};
      6'd15:   i = '{OP_SUB,   DST_T3, SRC_T3,  SRC_Y};
      6'd16:   i = '{OP_MUL16, DST_T3, SRC_H,   SRC_T3};
      6'd17:   i = '{OP_ADD,   DST_T3, SRC_Y,   SRC_T3};
      6'd18:   i = '{OP_MUL16, DST_T4, SRC_SIG, SRC_Y};
      6'd19:   i = '{OP_MUL16, DST_T4, SRC_T4,  SRC_T0};
      // z update
      6'd20:   i = '{OP_MUL12, DST_T5, SRC_SPR, SRC_NC};
      6'd21:   i = '{OP_ADD,   DST_T5, SRC_ONE, SRC_T5};
      6'd22:   i = '{OP_MUL16, DST_T5, SRC_C,   SRC_T5};
      6'd23:   i = '{OP_MUL16, DST_T5, SRC_T5,  SRC_Z};
      6'd24:   i = '{OP_MUL16, DST_T6, SRC_X,   SRC_Y};
      6'd25:   i = '{OP_SUB,   DST_T5, SRC_T6,  SRC_T5};
      6'd26:   i = '{OP_MUL16, DST_T5, SRC_H,   SRC_T5};
      6'd27:   i = '{OP_ADD,   DST_T5, SRC_Z,   SRC_T5};
      6'd28:   i = '{OP_MUL16, DST_T6, SRC_SIG, SRC_Z};
      6'd29:   i = '{OP_MUL16, DST_T6, SRC_T6,  SRC_T0};
      // Commit the new point
      6'd30:   i = '{OP_ADD,   DST_X,  SRC_T1,  SRC_T2};
      6'd31:   i = '{OP_ADD,   DST_Y,  SRC_T3,  SRC_T4};
      6'd32:   i = '{OP_ADD,   DST_Z,  SRC_T5,  SRC_T6};
      default: i = '{OP_ADD,   DST_T7, SRC_T7,  SRC_T7};
    endcase
    prog = i;
  endfunction

endpackage

`default_nettype wire

/* design/stochastic_lorenz_step_core.sv */
// Stochastic Lorenz step core: a sequencer runs 33 operations through one shared
// multiply/add unit, with operands registered ahead of execution and results forwarded.
// Depends on slst_pkg, slst_alu and slst_cfg_regs.
// A step item issues its 33 operations one per cycle; the last one then finishes and the
// result register is filled. Input is ready again in that cycle, so no new item is taken
// while a step runs; a result still waiting holds the next finished step back. A load
// item gives no result. Reset restores the register defaults, clears the point and the
// step counter.
`timescale 1ns / 1ps
`default_nettype none

module stochastic_lorenz_step_core
  import slst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: start_x, start_y, start_z, offset_x, offset_y, offset_z,
  // noise_w, noise_a, noise_b, noise_c
  input  logic [255:0] s_axis_tdata,
  // tuser: kind
  input  logic [0:0]   s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: step_index, point_x, point_y, point_z
  output logic [111:0] m_axis_tdata,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [PcBits-1:0]     pc_q;
  logic                  ex_valid_q;
  instr_t                ex_instr_q;
  logic [31:0]           opa_q;
  logic [31:0]           opb_q;
  logic [31:0]           cur_x_q;
  logic [31:0]           cur_y_q;
  logic [31:0]           cur_z_q;
  logic [IndexBits-1:0]  count_q;
  logic [15:0]           nw_q;
  logic [15:0]           na_q;
  logic [15:0]           nb_q;
  logic [15:0]           nc_q;
  logic                  out_valid_q;
  logic [15:0]           out_idx_q;
  logic [31:0]           out_x_q;
  logic [31:0]           out_y_q;
  logic [31:0]           out_z_q;
  logic [31:0]           tmp_q [2**TmpAddrBits];

  cfg_t                  cfg;
  instr_t                cur_instr;
  logic [31:0]           alu_res;
  logic                  in_xfer;
  logic                  issue;
  logic                  ex_last;
  logic                  fwd_a;
  logic                  fwd_b;
  logic [31:0]           opa_d;
  logic [31:0]           opb_d;
  logic                  out_free;

  // Configuration registers
  slst_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // Shared arithmetic unit, fed from the operand registers
  slst_alu u_alu (
    .op_i  (ex_instr_q.op),
    .a_i   (opa_q),
    .b_i   (opb_q),
    .res_o (alu_res)
  );

  // Value of a named source, or the scratch entry read for it.
  function automatic logic [31:0] src_val(input src_e s, input logic [31:0] tmp_rd);
    logic [31:0] v;
    case (s)
      SRC_X:   v = cur_x_q;
      SRC_Y:   v = cur_y_q;
      SRC_Z:   v = cur_z_q;
      SRC_A:   v = {1'b0, cfg.coef_a};
      SRC_B:   v = {1'b0, cfg.coef_b};
      SRC_C:   v = {1'b0, cfg.coef_c};
      SRC_H:   v = {1'b0, cfg.step_h};
      SRC_SQH: v = {1'b0, cfg.sqrt_h};
      SRC_SIG: v = {1'b0, cfg.sigma};
      SRC_SPR: v = {1'b0, cfg.spread};
      SRC_NW:  v = {{16{nw_q[15]}}, nw_q};
      SRC_NA:  v = {{16{na_q[15]}}, na_q};
      SRC_NB:  v = {{16{nb_q[15]}}, nb_q};
      SRC_NC:  v = {{16{nc_q[15]}}, nc_q};
      SRC_ONE: v = QOne;
      default: v = tmp_rd;
    endcase
    src_val = v;
  endfunction

  // Handshake and issue control
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign issue         = (state_q == ST_RUN) && (pc_q != PcBits'(NumOps));
  assign ex_last       = ex_valid_q && (pc_q == PcBits'(NumOps));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cur_instr     = prog(pc_q);

  // Operand fetch with forwarding from the operation now executing
  always_comb begin
    fwd_a = ex_valid_q && (ex_instr_q.dst < DST_X) && (cur_instr.sa < SRC_X) &&
            (ex_instr_q.dst[TmpAddrBits-1:0] == cur_instr.sa[TmpAddrBits-1:0]);
    fwd_b = ex_valid_q && (ex_instr_q.dst < DST_X) && (cur_instr.sb < SRC_X) &&
            (ex_instr_q.dst[TmpAddrBits-1:0] == cur_instr.sb[TmpAddrBits-1:0]);
    opa_d = fwd_a ? alu_res
                  : src_val(cur_instr.sa, tmp_q[cur_instr.sa[TmpAddrBits-1:0]]);
    opb_d = fwd_b ? alu_res
                  : src_val(cur_instr.sb, tmp_q[cur_instr.sb[TmpAddrBits-1:0]]);
  end

  // Sequencer, point state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      ex_valid_q  <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      cur_z_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
    end else begin
      // A result leaves on its transfer; in ST_DONE the register is refilled instead.
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (kind_e'(s_axis_tuser[0]) == KIND_LOAD) begin
              cur_x_q <= sat_add(s_axis_tdata[31:0],   s_axis_tdata[127:96],  1'b0);
              cur_y_q <= sat_add(s_axis_tdata[63:32],  s_axis_tdata[159:128], 1'b0);
              cur_z_q <= sat_add(s_axis_tdata[95:64],  s_axis_tdata[191:160], 1'b0);
              count_q <= '0;
            end else begin
              state_q <= ST_RUN;
              pc_q    <= '0;
            end
          end
        end
        ST_RUN: begin
          ex_valid_q <= issue;
          if (issue) begin
            pc_q <= pc_q + PcBits'(1);
          end
          // The last three operations write the point back.
          if (ex_valid_q) begin
            case (ex_instr_q.dst)
              DST_X:   cur_x_q <= alu_res;
              DST_Y:   cur_y_q <= alu_res;
              DST_Z:   cur_z_q <= alu_res;
              default: ;
            endcase
          end
          if (ex_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= 16'(count_q);
            out_x_q     <= cur_x_q;
            out_y_q     <= cur_y_q;
            out_z_q     <= cur_z_q;
            count_q     <= count_q + IndexBits'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Noise samples, operand registers and scratch memory
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      nw_q <= s_axis_tdata[207:192];
      na_q <= s_axis_tdata[223:208];
      nb_q <= s_axis_tdata[239:224];
      nc_q <= s_axis_tdata[255:240];
    end
    if (issue) begin
      opa_q      <= opa_d;
      opb_q      <= opb_d;
      ex_instr_q <= cur_instr;
    end
    if (ex_valid_q && (ex_instr_q.dst < DST_X)) begin
      tmp_q[ex_instr_q.dst[TmpAddrBits-1:0]] <= alu_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_z_q, out_y_q, out_x_q, out_idx_q};

  // Checks on the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PcBits'(NumOps))
    else $error("program counter ran past the end of the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> !ex_valid_q)
    else $error("operation executing outside a step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser[0]) |=> (state_q == ST_RUN) && (pc_q == '0))
    else $error("step transfer did not start the program");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && !out_valid_q) |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished step was not moved to the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_valid_q && (ex_instr_q.dst == DST_X || ex_instr_q.dst == DST_Y ||
                    ex_instr_q.dst == DST_Z)) |-> (pc_q >= PcBits'(NumOps - 2)))
    else $error("point overwritten before the step finished reading it");

endmodule

`default_nettype wire

/* design/slst_alu.sv */
// Shared arithmetic unit of the stochastic Lorenz step core: one signed 32x32
// multiplier with floor shift and saturation, and a saturating add and subtract.
// Depends on slst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slst_alu
  import slst_pkg::*;
(
  input  alu_op_e     op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);

  logic signed [63:0] prod;
  logic signed [63:0] shifted;
  logic [31:0]        mul_res;

  // Full product; the arithmetic shift rounds toward minus infinity.
  assign prod = $signed(a_i) * $signed(b_i);

  always_comb begin
    shifted = (op_i == OP_MUL12) ? (prod >>> 12) : (prod >>> 16);
    if ((&shifted[63:31]) || !(|shifted[63:31])) begin
      mul_res = shifted[31:0];
    end else begin
      mul_res = shifted[63] ? SatMin : SatMax;
    end
  end

  // Result selection
  always_comb begin
    case (op_i)
      OP_MUL16: res_o = mul_res;
      OP_MUL12: res_o = mul_res;
      OP_ADD:   res_o = sat_add(a_i, b_i, 1'b0);
      OP_SUB:   res_o = sat_add(a_i, b_i, 1'b1);
      default:  res_o = mul_res;
    endcase
  end

endmodule

`default_nettype wire

/* design/slst_cfg_regs.sv */
// Configuration register bank of the stochastic Lorenz step core: seven
// 31-bit unsigned Q15.16 registers written through a plain write port.
// Depends on slst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slst_cfg_regs
  import slst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        we_i,
  input  logic [2:0]  index_i,
  input  logic [30:0] data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  // Write decode; an index past the last register is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_a <= ResetCoefA;
      cfg_q.coef_b <= ResetCoefB;
      cfg_q.coef_c <= ResetCoefC;
      cfg_q.step_h <= ResetStepH;
      cfg_q.sqrt_h <= ResetSqrtH;
      cfg_q.sigma  <= ResetSigma;
      cfg_q.spread <= ResetSpread;
    end else if (we_i) begin
      unique case (cfg_idx_e'(index_i))
        CFG_COEF_A: cfg_q.coef_a <= data_i;
        CFG_COEF_B: cfg_q.coef_b <= data_i;
        CFG_COEF_C: cfg_q.coef_c <= data_i;
        CFG_STEP_H: cfg_q.step_h <= data_i;
        CFG_SQRT_H: cfg_q.sqrt_h <= data_i;
        CFG_SIGMA:  cfg_q.sigma  <= data_i;
        CFG_SPREAD: cfg_q.spread <= data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
